@@ design/iws_pkg.sv @@
// ----------------------------------------------------------------------------
// iws_pkg: shared types and constants for the inter-arrival window statistics
// Payload structs, operation codes and default sizes.
// ----------------------------------------------------------------------------
package iws_pkg;

  localparam int unsigned WINDOW_DEPTH_DEFAULT = 128;
  localparam logic [7:0]  LIMIT_AT_RESET       = 8'd100;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0] arrival_count;
    logic [7:0]  sample_count;
    logic [31:0] min_interval_us;
    logic [31:0] max_interval_us;
    logic [39:0] mean_q8;
    logic [39:0] stddev_q8;
  } out_item_t;

endpackage

@@ design/iws_ram.sv @@
// ----------------------------------------------------------------------------
// iws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module iws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/iws_divider.sv @@
// ----------------------------------------------------------------------------
// iws_divider: restoring divider, one quotient bit per cycle
// Divides a 90-bit dividend by an 11-bit divisor.
// ----------------------------------------------------------------------------
module iws_divider #(
  parameter int unsigned NW = 90,
  parameter int unsigned DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;

  assign shifted  = {rem[DW-1:0], quo[NW-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= shifted - {1'b0, dvs};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/iws_sqrt.sv @@
// ----------------------------------------------------------------------------
// iws_sqrt: digit-by-digit integer square root, one result bit per cycle
// Floor root of a 90-bit radicand, 45-bit result.
// ----------------------------------------------------------------------------
module iws_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [89:0] radicand,
  output logic        done,
  output logic [44:0] root
);

  logic [89:0] rad;
  logic [45:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [47:0] trial;
  logic [47:0] cand;
  logic [47:0] diff;

  assign trial = {rem, rad[89:88]};
  assign cand  = {1'b0, root, 2'b01};
  assign diff  = trial - cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd45;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[87:0], 2'b00};
        if (trial >= cand) begin
          rem  <= diff[45:0];
          root <= {root[43:0], 1'b1};
        end else begin
          rem  <= trial[45:0];
          root <= {root[43:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/interarrival_window_stats.sv @@
// ----------------------------------------------------------------------------
// interarrival_window_stats: sliding-window inter-arrival jitter statistics
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry an operation and a timestamp. An
// arrival stores the interval from the previous arrival into a circular
// window held in one RAM and bumps a saturating counter; it produces no
// output beat. A query walks the window through the RAM read port (one
// entry per cycle) and divides for the mean, then walks it again and divides
// for the variance, and takes a square root for the standard deviation.
// The query result sits in an output register (out_valid/out_ready); a
// stalled receiver holds it there, and the next input beat is taken while it
// waits unless it is another query.
// The window_limit register is written with cfg_we/cfg_data; the user must
// write it only while idle, which the block does not enforce. Reset (rst,
// synchronous) empties the window, clears the counters and sets the limit
// to 100; the RAM needs no clearing pass: only written entries are ever read.
// ----------------------------------------------------------------------------
module interarrival_window_stats
  import iws_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = 32 + FW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS1 = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_PASS2 = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_ARR   = 3'd6;

  logic [2:0]    state;
  logic [7:0]    window_limit;
  logic [31:0]   last_time;
  logic          seen_first;
  logic [FW-1:0] fill;
  logic [AW-1:0] wslot;
  logic [31:0]   arrivals;
  logic [31:0]   ts;

  logic [FW-1:0] lim;
  logic [FW-1:0] rd_left;
  logic [AW-1:0] raddr;
  logic [AW-1:0] last_slot;
  logic          rd_en;
  logic          rd_valid;
  logic [31:0]   rdata;
  logic          ram_we;

  logic [31:0]   mn, mx;
  logic [SW-1:0] sum;
  logic [39:0]   mean;
  logic [89:0]   acc;
  logic [39:0]   dev;
  logic [39:0]   pp_hh, pp_hl, pp_ll;
  logic          sq_valid;
  logic          div_start, div_done, sq_start, sq_done;
  logic [89:0]   div_num, div_q;
  logic [44:0]   root;
  logic [39:0]   xs;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready && in_data.operation);
  assign ram_we   = (state == S_ARR) && seen_first;
  assign last_slot = (wslot == '0) ? AW'(WINDOW_DEPTH - 1) : wslot - 1'b1;

  always_comb begin
    if (window_limit == 8'd0) begin
      lim = FW'(1);
    end else if ({24'd0, window_limit} > 32'(WINDOW_DEPTH)) begin
      lim = FW'(WINDOW_DEPTH);
    end else begin
      lim = FW'(window_limit);
    end
  end

  iws_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata (ts - last_time),
    .raddr (raddr),
    .rdata (rdata)
  );

  iws_divider #(.NW(90), .DW(FW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_q)
  );

  iws_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (div_q),
    .done     (sq_done),
    .root     (root)
  );

  assign xs  = {rdata, 8'd0};
  assign dev = (xs >= mean) ? xs - mean : mean - xs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_limit <= LIMIT_AT_RESET;
      last_time    <= '0;
      seen_first   <= 1'b0;
      fill         <= '0;
      wslot        <= '0;
      arrivals     <= '0;
      out_valid    <= 1'b0;
      rd_en        <= 1'b0;
      rd_valid     <= 1'b0;
      sq_valid     <= 1'b0;
      div_start    <= 1'b0;
      sq_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      rd_valid  <= rd_en;
      sq_valid  <= rd_valid && (state == S_PASS2);
      if (cfg_we) begin
        window_limit <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ts <= in_data.timestamp_us;
            if (in_data.operation == OP_ARRIVAL) begin
              state <= S_ARR;
            end else if (fill == '0) begin
              out_data  <= '{arrival_count: arrivals, sample_count: 8'(fill),
                             min_interval_us: '0, max_interval_us: '0,
                             mean_q8: '0, stddev_q8: '0};
              out_valid <= 1'b1;
            end else begin
              state   <= S_PASS1;
              rd_left <= fill;
              raddr   <= last_slot;
              rd_en   <= 1'b1;
              mn      <= '1;
              mx      <= '0;
              sum     <= '0;
            end
          end
        end
        S_ARR: begin
          // write interval (via ram_we), then advance pointers
          if (arrivals != '1) begin
            arrivals <= arrivals + 1'b1;
          end
          if (seen_first) begin
            wslot <= (wslot == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot + 1'b1;
            fill  <= (fill >= lim) ? lim : fill + 1'b1;
          end
          seen_first <= 1'b1;
          last_time  <= ts;
          state      <= S_IDLE;
        end
        S_PASS1, S_PASS2: begin
          if (rd_en) begin
            raddr   <= (raddr == '0) ? AW'(WINDOW_DEPTH - 1) : raddr - 1'b1;
            rd_left <= rd_left - 1'b1;
            if (rd_left == FW'(1)) begin
              rd_en <= 1'b0;
            end
          end
          if (rd_valid && state == S_PASS1) begin
            if (rdata < mn) mn <= rdata;
            if (rdata > mx) mx <= rdata;
            sum <= sum + SW'(rdata);
          end
          // split the squared deviation into partial products of 20-bit halves
          if (rd_valid) begin
            pp_hh <= dev[39:20] * dev[39:20];
            pp_hl <= dev[39:20] * dev[19:0];
            pp_ll <= dev[19:0] * dev[19:0];
          end
          if (sq_valid) begin
            acc <= acc + {10'd0, pp_hh, 40'd0} + {29'd0, pp_hl, 21'd0} + {50'd0, pp_ll};
          end
          if (state == S_PASS1 && !rd_en && !rd_valid) begin
            div_num   <= 90'({sum, 8'd0});
            div_start <= 1'b1;
            state     <= S_DIV1;
          end
          if (state == S_PASS2 && !rd_en && !rd_valid && !sq_valid) begin
            div_num   <= acc;
            div_start <= 1'b1;
            state     <= S_DIV2;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            mean    <= div_q[39:0];
            acc     <= '0;
            rd_left <= fill;
            raddr   <= last_slot;
            rd_en   <= 1'b1;
            state   <= S_PASS2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            sq_start <= 1'b1;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            out_data  <= '{arrival_count: arrivals, sample_count: 8'(fill),
                           min_interval_us: mn, max_interval_us: mx,
                           mean_q8: mean, stddev_q8: 40'(root)};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH)) else $error("fill exceeds depth");
  a_no_ram_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS1 || state == S_PASS2) |-> !ram_we) else $error("write during walk");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data)) else $error("result lost");
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1) |-> mn <= mx) else $error("min above max");
`endif

endmodule

@@ tb/sv/iws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iws_checker: scoreboard for the inter-arrival window statistics block
// Watches the input and output channels. Keeps its own copy of the window,
// computes the statistics of every query beat and compares each output beat
// against the oldest pending expectation, reporting mismatches field by field.
// ----------------------------------------------------------------------------
module iws_checker
  import iws_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  output int        fail_count,
  output int        pending_count,
  output int        query_count
);

  localparam int unsigned EXP_DEPTH = 16;

  logic [7:0]  limit_reg;
  logic [31:0] prev_time;
  logic        have_first;
  logic [31:0] intervals [WINDOW_DEPTH];
  int unsigned fill;
  int unsigned slot;
  logic [31:0] arrivals;
  out_item_t   expected [EXP_DEPTH];
  int unsigned exp_head;
  int unsigned exp_tail;

  function automatic out_item_t window_stats();
    out_item_t   r;
    logic [63:0] total;
    logic [63:0] mean;
    logic [63:0] dev;
    logic [127:0] sq_sum;
    logic [127:0] var_q;
    logic [63:0] root;
    logic [63:0] cand;
    logic [31:0] x;
    int unsigned idx;
    r = '0;
    r.arrival_count = arrivals;
    r.sample_count = fill[7:0];
    if (fill != 0) begin
      total = 0;
      r.min_interval_us = 32'hFFFF_FFFF;
      for (int k = 0; k < fill; k++) begin
        idx = (slot + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH;
        x = intervals[idx];
        if (x < r.min_interval_us) r.min_interval_us = x;
        if (x > r.max_interval_us) r.max_interval_us = x;
        total += x;
      end
      mean = (total << 8) / fill;
      sq_sum = 0;
      for (int k = 0; k < fill; k++) begin
        idx = (slot + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH;
        dev = {24'd0, intervals[idx], 8'd0};
        dev = (dev >= mean) ? dev - mean : mean - dev;
        sq_sum += 128'(dev) * 128'(dev);
      end
      var_q = sq_sum / fill;
      root = 0;
      for (int b = 45; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= var_q) root = cand;
      end
      r.mean_q8 = mean[39:0];
      r.stddev_q8 = root[39:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    int unsigned lim;
    out_item_t want;
    if (rst) begin
      limit_reg <= LIMIT_AT_RESET;
      prev_time <= '0;
      have_first <= 1'b0;
      fill <= 0;
      slot <= 0;
      arrivals <= '0;
      exp_head <= 0;
      exp_tail <= 0;
      fail_count <= 0;
      query_count <= 0;
    end else begin
      if (cfg_we) limit_reg <= cfg_data;
      if (out_valid && out_ready) begin
        if (exp_tail == exp_head) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("%0t: unexpected result beat %h", $realtime, out_data);
        end else begin
          want = expected[exp_head % EXP_DEPTH];
          exp_head <= exp_head + 1;
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"%0t: mismatch cnt %0d/%0d n %0d/%0d min %0d/%0d max %0d/%0d",
                        " mean %0d/%0d sd %0d/%0d"},
                $realtime, want.arrival_count, out_data.arrival_count, want.sample_count,
                out_data.sample_count, want.min_interval_us, out_data.min_interval_us,
                want.max_interval_us, out_data.max_interval_us, want.mean_q8,
                out_data.mean_q8, want.stddev_q8, out_data.stddev_q8);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_ARRIVAL) begin
          lim = (limit_reg == 0) ? 1 : limit_reg;
          if (lim > WINDOW_DEPTH) lim = WINDOW_DEPTH;
          if (arrivals != 32'hFFFF_FFFF) arrivals <= arrivals + 1;
          if (have_first) begin
            intervals[slot] <= in_data.timestamp_us - prev_time;
            slot <= (slot + 1) % WINDOW_DEPTH;
            fill <= (fill + 1 > lim) ? lim : fill + 1;
          end
          have_first <= 1'b1;
          prev_time <= in_data.timestamp_us;
        end else begin
          expected[exp_tail % EXP_DEPTH] <= window_stats();
          exp_tail <= exp_tail + 1;
          query_count <= query_count + 1;
        end
      end
    end
  end

  assign pending_count = int'(exp_tail - exp_head);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for interarrival_window_stats
// Directed arrivals and queries over edge timestamps, then random traffic
// across several window limits with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import iws_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  int        fail_count;
  int        pending_count;
  int        query_count;
  int        sent = 0;
  bit        long_stall = 1'b0;
  logic [31:0] now_us = '0;

  always #5 clk = ~clk;

  interarrival_window_stats uut (.*);

  iws_checker chk (.*);

  // Valid stays high across back-to-back beats; drop it only for a gap.
  task automatic send_beat(input logic op, input logic [31:0] ts);
    int unsigned idle;
    idle = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, timestamp_us: ts};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short jitter, sometimes huge steps that wrap the timestamp.
  task automatic arrive_random();
    logic [31:0] step;
    case ($urandom_range(0, 9))
      0: step = $urandom();
      1: step = 0;
      default: step = $urandom_range(900, 1100);
    endcase
    now_us += step;
    send_beat(OP_ARRIVAL, now_us);
  endtask

  initial begin
    logic [7:0] limits [6] = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd7, 8'd100};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty window, first arrival only, then extremes and wraparound
    send_beat(OP_QUERY, 32'hFFFF_FFFF);
    send_beat(OP_ARRIVAL, 32'hFFFF_FFF0);
    send_beat(OP_QUERY, 32'h0);
    send_beat(OP_ARRIVAL, 32'h0000_0010);
    send_beat(OP_ARRIVAL, 32'h0000_0010);
    send_beat(OP_ARRIVAL, 32'h0000_000F);
    send_beat(OP_QUERY, 32'h5555_5555);
    send_beat(OP_ARRIVAL, 32'hAAAA_AAAA);
    send_beat(OP_ARRIVAL, 32'h5555_5555);
    send_beat(OP_QUERY, 32'hAAAA_AAAA);
    now_us = 32'h5555_5555;
    // lower the limit under the fill; query before and after the next interval
    set_limit(8'd2);
    send_beat(OP_QUERY, 32'h0);
    send_beat(OP_ARRIVAL, now_us + 5);
    now_us += 5;
    send_beat(OP_QUERY, 32'h0);
    drain();
    foreach (limits[i]) begin
      set_limit(limits[i]);
      for (int j = 0; j < 150; j++) begin
        if ($urandom_range(0, 11) == 0) send_beat(OP_QUERY, $urandom());
        else arrive_random();
      end
      // a stalled receiver holds a result, so the next query backs up the input
      if (i == 2) begin
        long_stall = 1'b1;
        for (int j = 0; j < 6; j++) send_beat(OP_QUERY, $urandom());
        long_stall = 1'b0;
      end
      send_beat(OP_QUERY, $urandom());
    end
    drain();
    $display("Sent %0d beats over %0d window limits, %0d queries checked incl. wrap and stalls.",
      sent, $size(limits) + 1, query_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    int hold;
    if (long_stall) begin
      out_ready <= 1'b0;
      for (hold = 0; hold < 400; hold++) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
    end else if ($urandom_range(0, 1) == 0) begin
      out_ready <= 1'b1;
    end else begin
      hold = $urandom_range(0, 9);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/iws_pkg.sv
design/iws_ram.sv
design/iws_divider.sv
design/iws_sqrt.sv
design/interarrival_window_stats.sv
tb/sv/iws_checker.sv
tb/sv/tb_top.sv
